@@ rtl/ordered_list_deque_with_search_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list deque
// Concurrent check helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH
`define ORDERED_LIST_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge while out of reset
`define OLDQ_ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("oldq assertion failed");

// Check a property on every clock edge, reset included
`define OLDQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("oldq assertion failed");

`else

`define OLDQ_ASSERT_RST(label, clk, rstn, prop)
`define OLDQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ rtl/oldq_pkg.sv @@
// ----------------------------------------------------------------------------
// oldq_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oldq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_READ_ALL   = 3'd4,
        ACT_CLEAR      = 3'd5,
        ACT_SEARCH     = 3'd6,
        ACT_REMOVE     = 3'd7
    } act_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } stat_t;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_PUSH_BACK  = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_POP_BACK   = 4'd4,
        OP_CLEAR      = 4'd5,
        OP_IDX_CLEAR  = 4'd6,
        OP_IDX_INC    = 4'd7,
        OP_SHIFT      = 4'd8,
        OP_DEC        = 4'd9
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   load_item;
        logic   hold_load;
        logic   out_load;
        logic   out_from_hold;
        stat_t  res_status;
        logic   res_use_rd;
        logic   out_last;
    } oldq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        act_t             act;
        logic             empty;
        logic             full;
        logic             rd_last;
        logic             match;
        logic             shift_more;
        logic             out_free;
        logic [CNT_W-1:0] entry_count;
    } oldq_stat_t;

endpackage

@@ rtl/oldq_dp.sv @@
// ----------------------------------------------------------------------------
// oldq_dp
// Ring storage, front/count pointers, walk index and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oldq_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  oldq_pkg::oldq_cmd_t       cmd,
    output oldq_pkg::oldq_stat_t      stat,
    input  logic [2:0]                s_tuser,
    input  logic [oldq_pkg::DATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [oldq_pkg::DATA_W-1:0] m_tdata,
    output logic [1:0]                m_tuser,
    output logic                      m_tlast
);
    import oldq_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [PTR_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    act_t              act_reg;
    logic [DATA_W-1:0] val_reg;
    stat_t             hold_status_reg;
    logic [DATA_W-1:0] hold_value_reg;
    logic              out_valid_reg, out_valid_next;
    stat_t             out_status_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;

    logic [CNT_W-1:0]  rd_off;
    logic [PTR_W-1:0]  rd_slot;
    logic [PTR_W-1:0]  idx_slot;
    logic [PTR_W-1:0]  back_slot;
    logic [PTR_W-1:0]  dec_front;
    logic [PTR_W-1:0]  inc_front;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] res_value;
    logic [CNT_W-1:0]  idx_plus1;

    // Ring position of an offset from the front; sum stays below 2*CAPACITY
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] f,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(f) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign idx_plus1 = idx_reg + CNT_W'(1);

    always_comb begin
        case (cmd.op)
            OP_POP_FRONT: rd_off = '0;
            OP_POP_BACK:  rd_off = count_reg - CNT_W'(1);
            OP_SHIFT:     rd_off = idx_plus1;
            default:      rd_off = idx_reg;
        endcase
    end

    assign rd_slot   = slot_of(front_reg, rd_off);
    assign idx_slot  = slot_of(front_reg, idx_reg);
    assign back_slot = slot_of(front_reg, count_reg);
    assign rd_data   = mem[rd_slot];
    assign dec_front = (front_reg == '0) ? PTR_W'(CAPACITY - 1) : front_reg - PTR_W'(1);
    assign inc_front = (front_reg == PTR_W'(CAPACITY - 1)) ? '0 : front_reg + PTR_W'(1);
    assign res_value = cmd.res_use_rd ? rd_data : '0;

    // Pointer and index updates
    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        case (cmd.op)
            OP_PUSH_FRONT: begin
                front_next = dec_front;
                count_next = count_reg + CNT_W'(1);
            end
            OP_PUSH_BACK:  count_next = count_reg + CNT_W'(1);
            OP_POP_FRONT: begin
                front_next = inc_front;
                count_next = count_reg - CNT_W'(1);
            end
            OP_POP_BACK:   count_next = count_reg - CNT_W'(1);
            OP_CLEAR: begin
                front_next = '0;
                count_next = '0;
            end
            OP_IDX_CLEAR:  idx_next = '0;
            OP_IDX_INC:    idx_next = idx_plus1;
            OP_SHIFT:      idx_next = idx_plus1;
            OP_DEC:        count_next = count_reg - CNT_W'(1);
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Storage: no reset, only occupied slots are ever read
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_PUSH_FRONT: mem[dec_front] <= val_reg;
            OP_PUSH_BACK:  mem[back_slot] <= val_reg;
            OP_SHIFT:      mem[idx_slot]  <= rd_data;
            default: ;
        endcase
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg <= act_t'(s_tuser);
            val_reg <= s_tdata;
        end
        if (cmd.hold_load) begin
            hold_status_reg <= cmd.res_status;
            hold_value_reg  <= res_value;
        end
        if (cmd.out_load) begin
            out_last_reg <= cmd.out_last;
            if (cmd.out_from_hold) begin
                out_status_reg <= hold_status_reg;
                out_value_reg  <= hold_value_reg;
            end else begin
                out_status_reg <= cmd.res_status;
                out_value_reg  <= res_value;
            end
        end
    end

    assign stat.act         = act_reg;
    assign stat.empty       = (count_reg == '0);
    assign stat.full        = (count_reg == CNT_W'(CAPACITY));
    assign stat.rd_last     = (idx_plus1 == count_reg);
    // Compare at the walk index directly so the status never depends on cmd
    assign stat.match       = (mem[idx_slot] == val_reg);
    assign stat.shift_more  = (idx_plus1 < count_reg);
    assign stat.out_free    = !out_valid_reg || m_tready;
    assign stat.entry_count = count_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/oldq_ctrl.sv @@
// ----------------------------------------------------------------------------
// oldq_ctrl
// Sequencer: decodes the action and steps the datapath through each walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oldq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  oldq_pkg::oldq_stat_t  stat,
    output oldq_pkg::oldq_cmd_t   cmd
);
    import oldq_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_READ     = 6'b000100,
        ST_SCAN     = 6'b001000,
        ST_SHIFT    = 6'b010000,
        ST_FIN      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.res_status = STAT_OK;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (stat.out_free) begin
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                    case (stat.act)
                        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                            cmd.out_load = 1'b1;
                            if (stat.full) begin
                                cmd.res_status = STAT_FULL;
                            end else begin
                                cmd.op = (stat.act == ACT_PUSH_FRONT) ? OP_PUSH_FRONT
                                                                      : OP_PUSH_BACK;
                            end
                        end
                        ACT_POP_FRONT, ACT_POP_BACK: begin
                            cmd.out_load = 1'b1;
                            if (stat.empty) begin
                                cmd.res_status = STAT_EMPTY;
                            end else begin
                                cmd.op = (stat.act == ACT_POP_FRONT) ? OP_POP_FRONT
                                                                     : OP_POP_BACK;
                                cmd.res_use_rd = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            cmd.out_load = 1'b1;
                            cmd.op       = OP_CLEAR;
                        end
                        default: begin
                            // read all, search, remove: walk from the front
                            if (stat.empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.res_status = STAT_EMPTY;
                            end else begin
                                cmd.op     = OP_IDX_CLEAR;
                                state_next = (stat.act == ACT_READ_ALL) ? ST_READ : ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.res_use_rd = 1'b1;
                    cmd.out_last   = stat.rd_last;
                    cmd.op         = OP_IDX_INC;
                    if (stat.rd_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (stat.match) begin
                    cmd.hold_load  = 1'b1;
                    cmd.res_use_rd = 1'b1;
                    state_next     = (stat.act == ACT_REMOVE) ? ST_SHIFT : ST_FIN;
                end else if (stat.rd_last) begin
                    cmd.hold_load  = 1'b1;
                    cmd.res_status = STAT_NOT_FOUND;
                    state_next     = ST_FIN;
                end else begin
                    cmd.op = OP_IDX_INC;
                end
            end
            ST_SHIFT: begin
                // close the gap one entry a cycle, then drop the back
                if (stat.shift_more) begin
                    cmd.op = OP_SHIFT;
                end else begin
                    cmd.op     = OP_DEC;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load      = 1'b1;
                    cmd.out_from_hold = 1'b1;
                    cmd.out_last      = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/ordered_list_deque_with_search_top.sv @@
// ----------------------------------------------------------------------------
// ordered_list_deque_with_search_top
// Ordered list of signed 32-bit values with deque access, readout and search.
// ----------------------------------------------------------------------------
// The block holds up to 16 values in a ring with a front pointer and a count.
// Each input item carries an action in s_tuser and a value in s_tdata; every
// action gives one result item with m_tlast set, except read all, which gives
// one item per entry from front to back with m_tlast on the back entry. The
// block works on one item at a time. Read all, search and remove by value walk
// the list from the front one entry per cycle (read all only while the output
// register is free to take a result), and removal then moves each later entry
// down one slot, also one per cycle. A finished result sits in the output
// register, so the next item can be taken while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ordered_list_deque_with_search_top_assert.svh"

module ordered_list_deque_with_search_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_res
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import oldq_pkg::*;

    oldq_cmd_t  cmd;
    oldq_stat_t stat;

    // Sequencer: decode the action, step the walks, schedule results
    oldq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage, pointers and output register
    oldq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Count never passes the capacity
    `OLDQ_ASSERT_RST(a_count_bound, aclk, aresetn, stat.entry_count <= CNT_W'(CAPACITY))
    // Never overwrite a result the sink has not taken
    `OLDQ_ASSERT_RST(a_out_free, aclk, aresetn, cmd.out_load |-> stat.out_free)
    // No insert goes through on a full list
    `OLDQ_ASSERT_RST(a_no_push_full, aclk, aresetn,
        (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK) |-> !stat.full)
    // After an item is taken, hold off the next one
    `OLDQ_ASSERT_RST(a_one_item, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)

endmodule

@@ bench/ordered_list_deque_with_search_top_tb.sv @@
// ----------------------------------------------------------------------------
// Ordered list deque testbench
// Drives action/value items through the input stream and checks every result
// item against a behavioral copy of the list kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_deque_with_search_top_tb;

    import oldq_pkg::*;

    // Result item as seen on the output stream
    typedef struct packed {
        stat_t       status;
        logic [31:0] value;
        logic        last;
    } list_res_t;

    // One row of the directed table; the typed columns apply when known is set
    typedef struct packed {
        act_t        act;
        logic [31:0] value;
        logic        known;
        stat_t       want_status;
        logic [31:0] want_value;
    } dir_row_t;

    // Shapes of the random traffic
    typedef enum logic [1:0] {
        EP_FILL,    // push until full, overshoot, then read back
        EP_HUNT,    // search/remove, mostly for values that are present
        EP_DRAIN,   // pop until empty, overshoot
        EP_MIX      // anything goes
    } episode_t;

    localparam int NUM_DIR      = 25;
    localparam int RAND_ITEMS   = 85;
    localparam int MAX_MISMATCH = 10;
    localparam int DRAIN_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] value
    logic [2:0]  s_tuser;    // [2:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] value_res
    logic [1:0]  m_tuser;    // [1:0] status
    logic        m_tlast;

    // Behavioral copy of the ring
    logic [31:0] list_mem [CAPACITY];
    int          head_idx;
    int          list_len;

    list_res_t   fresh_results[$];     // results of the item just accepted
    list_res_t   pending_results[$];   // results still owed by the block
    int          mismatch_cnt;
    int          tx_calm;
    int          rx_calm;

    // Directed table: empty-list cases, extremes, duplicates, ring wrap,
    // near misses, clear on a non-empty list
    dir_row_t dir_rows [NUM_DIR] = '{
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, STAT_EMPTY,     32'h0000_0000},
        '{ACT_POP_BACK,   32'h0000_0000, 1'b1, STAT_EMPTY,     32'h0000_0000},
        '{ACT_READ_ALL,   32'h0000_0000, 1'b1, STAT_EMPTY,     32'h0000_0000},
        '{ACT_SEARCH,     32'h0000_0000, 1'b1, STAT_EMPTY,     32'h0000_0000},
        '{ACT_REMOVE,     32'h0000_0000, 1'b1, STAT_EMPTY,     32'h0000_0000},
        '{ACT_CLEAR,      32'h0000_0000, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_PUSH_BACK,  32'h0000_0000, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_READ_ALL,   32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
        '{ACT_SEARCH,     32'h1234_5678, 1'b1, STAT_NOT_FOUND, 32'h0000_0000},
        '{ACT_SEARCH,     32'h8000_0000, 1'b1, STAT_OK,        32'h8000_0000},
        '{ACT_REMOVE,     32'h7FFF_FFFF, 1'b1, STAT_OK,        32'h7FFF_FFFF},
        '{ACT_READ_ALL,   32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000},
        '{ACT_REMOVE,     32'h5555_5555, 1'b1, STAT_NOT_FOUND, 32'h0000_0000},
        '{ACT_SEARCH,     32'h7FFF_FFFE, 1'b1, STAT_NOT_FOUND, 32'h0000_0000},
        '{ACT_POP_BACK,   32'h0000_0000, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, STAT_OK,        32'h8000_0000},
        '{ACT_REMOVE,     32'hFFFF_FFFF, 1'b1, STAT_OK,        32'hFFFF_FFFF},
        '{ACT_CLEAR,      32'h0000_0000, 1'b1, STAT_OK,        32'h0000_0000},
        '{ACT_READ_ALL,   32'h0000_0000, 1'b1, STAT_EMPTY,     32'h0000_0000},
        '{ACT_PUSH_FRONT, 32'h0000_0001, 1'b0, STAT_OK,        32'h0000_0000},
        '{ACT_READ_ALL,   32'h0000_0000, 1'b0, STAT_OK,        32'h0000_0000}
    };

    ordered_list_deque_with_search_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // List predictor
    // ------------------------------------------------------------------------

    // Ring index of the entry at a given distance from the front
    function automatic int ring_slot(input int offset);
        return (head_idx + offset) % CAPACITY;
    endfunction

    function automatic void add_result(input stat_t st, input logic [31:0] v,
                                       input logic lst);
        list_res_t r;
        r.status = st;
        r.value  = v;
        r.last   = lst;
        fresh_results.push_back(r);
    endfunction

    // Update the list copy for one accepted item and queue what it yields
    function automatic void predict_action(input act_t act, input logic [31:0] v);
        int hit;
        int k;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (list_len >= CAPACITY) begin
                    // full list rejects the insert and stays as it is
                    add_result(STAT_FULL, '0, 1'b1);
                end else begin
                    if (act == ACT_PUSH_FRONT) begin
                        head_idx = (head_idx + CAPACITY - 1) % CAPACITY;
                        list_mem[head_idx] = v;
                    end else begin
                        list_mem[ring_slot(list_len)] = v;
                    end
                    list_len++;
                    add_result(STAT_OK, '0, 1'b1);
                end
            end
            ACT_POP_FRONT: begin
                if (list_len == 0) begin
                    add_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    add_result(STAT_OK, list_mem[head_idx], 1'b1);
                    head_idx = ring_slot(1);
                    list_len--;
                end
            end
            ACT_POP_BACK: begin
                if (list_len == 0) begin
                    add_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    add_result(STAT_OK, list_mem[ring_slot(list_len - 1)], 1'b1);
                    list_len--;
                end
            end
            ACT_READ_ALL: begin
                if (list_len == 0) begin
                    add_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    for (k = 0; k < list_len; k++)
                        add_result(STAT_OK, list_mem[ring_slot(k)], k == list_len - 1);
                end
            end
            ACT_CLEAR: begin
                head_idx = 0;
                list_len = 0;
                add_result(STAT_OK, '0, 1'b1);
            end
            default: begin
                // search and remove: first exact match from the front
                if (list_len == 0) begin
                    add_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    hit = -1;
                    for (k = 0; k < list_len && hit < 0; k++)
                        if (list_mem[ring_slot(k)] == v)
                            hit = k;
                    if (hit < 0) begin
                        add_result(STAT_NOT_FOUND, '0, 1'b1);
                    end else begin
                        add_result(STAT_OK, list_mem[ring_slot(hit)], 1'b1);
                        if (act == ACT_REMOVE) begin
                            // close the gap: later entries move one toward the front
                            for (k = hit; k + 1 < list_len; k++)
                                list_mem[ring_slot(k)] = list_mem[ring_slot(k + 1)];
                            list_len--;
                        end
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle gap before the next item: drawn at random, with calm stretches of no gap
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm_left = $urandom_range(4, 20);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // Value mix: extremes and a small pool to force duplicates, else any pattern
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4, 5:    return 32'($urandom_range(1, 4));
            default: return $urandom;
        endcase
    endfunction

    // Mostly a value already in the list, so search/remove hit
    function automatic logic [31:0] pick_present();
        if (list_len > 0 && $urandom_range(0, 3) != 0)
            return list_mem[ring_slot($urandom_range(0, list_len - 1))];
        return pick_value();
    endfunction

    // Offer one item, hold it until accepted, then record what it owes.
    // A typed expectation replaces the predicted one for single-result rows.
    task automatic send_item(input act_t act, input logic [31:0] v,
                             input logic known, input stat_t st,
                             input logic [31:0] res);
        int gap;
        list_res_t r;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_action(act, v);
        if (known) begin
            r.status = st;
            r.value  = res;
            r.last   = 1'b1;
            fresh_results = '{r};
        end
        while (fresh_results.size() != 0)
            pending_results.push_back(fresh_results.pop_front());
    endtask

    task automatic send_random(input act_t act, input logic [31:0] v);
        send_item(act, v, 1'b0, STAT_OK, '0);
    endtask

    // ------------------------------------------------------------------------
    // Result checking: compare every accepted result with the oldest one owed
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        list_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_MISMATCH)
                    $display("unexpected result: status %0d value %h last %0b",
                             m_tuser, m_tdata, m_tlast);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status || m_tdata !== want.value ||
                    m_tlast !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_MISMATCH) begin
                        $display("mismatch: expected status %0d value %h last %0b",
                                 want.status, want.value, want.last);
                        $display("          got      status %0d value %h last %0b",
                                 m_tuser, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: stall the output stream a random number of cycles per item
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        rx_calm = 0;
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            stall = draw_gap(rx_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            // hold ready until the block hands over one item
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random episodes, drain, verdict
    // ------------------------------------------------------------------------
    initial begin
        int       sent;
        int       n;
        int       k;
        episode_t ep;

        mismatch_cnt = 0;
        tx_calm      = 0;
        head_idx     = 0;
        list_len     = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_PUSH_FRONT;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: walk the table row by row
        for (k = 0; k < NUM_DIR; k++)
            send_item(dir_rows[k].act, dir_rows[k].value, dir_rows[k].known,
                      dir_rows[k].want_status, dir_rows[k].want_value);

        // Random part: the first episode always fills the list to full so the
        // rejected insert shows up early; after that pick shapes at random
        sent = 0;
        ep   = EP_FILL;
        while (sent < RAND_ITEMS) begin
            case (ep)
                EP_FILL: begin
                    n = CAPACITY - list_len + $urandom_range(1, 2);
                    for (k = 0; k < n; k++)
                        send_random($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                                    pick_value());
                    send_random(ACT_READ_ALL, $urandom);
                    sent += n + 1;
                end
                EP_HUNT: begin
                    n = $urandom_range(3, 6);
                    for (k = 0; k < n; k++)
                        send_random($urandom_range(0, 1) ? ACT_SEARCH : ACT_REMOVE,
                                    pick_present());
                    sent += n;
                end
                EP_DRAIN: begin
                    n = list_len + 1;
                    for (k = 0; k < n; k++)
                        send_random($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK,
                                    $urandom);
                    sent += n;
                end
                default: begin
                    n = $urandom_range(4, 10);
                    for (k = 0; k < n; k++)
                        send_random(act_t'(3'($urandom_range(0, 7))), pick_present());
                    sent += n;
                end
            endcase
            ep = episode_t'(2'($urandom_range(0, 3)));
        end
        s_tvalid <= 1'b0;

        // Wait for every owed result, then leave room for anything stray
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (full readouts, longest stalls)
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
